FILE: rtl/fbpa_pkg.sv
// Shared types and constants of the fixed-size block pool allocator.
package fbpa_pkg;

	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 17;
	localparam int COUNT_W = 9;
	localparam int USED_W  = 9;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [USED_W-1:0] USED_LIMIT = 9'd511;

	// Register indexes on the configuration port (byte address = 4 * index).
	localparam logic [1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
	localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FREED     = 2'd2,
		ST_REJECTED  = 2'd3
	} status_t;

	typedef struct packed {
		op_t               opcode;
		logic [ADDR_W-1:0] address;
	} item_in_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] block_address;
		logic [USED_W-1:0] used_count;
	} item_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init_start;
		logic sweep_step;
		logic capture;
		logic alloc_mul;
		logic alloc_commit;
		logic emit_empty;
		logic free_setup;
		logic free_commit;
		logic free_reject;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last;
		logic head_valid;
		logic req_free;
		logic div_done;
		logic free_ok;
	} stat_t;

endpackage

FILE: rtl/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator: register file, controller, datapath.
//
//  Channel   Ports                                  Handshake
//  request   start, request, busy                   taken when start is high and busy is low
//  result    done, result                           one cycle per item, receiver cannot stall
//  config    psel, penable, pwrite, paddr, pwdata,  APB write in setup and access cycles,
//            prdata, pready                         pready always high
//
// An allocate item, when the list has a free block, multiplies the list head index by the
// block size, then commits it with the registered link memory read; when the pool is empty
// it reports empty instead. A free item divides the offset into the pool by the block size
// in a serial divider that yields one quotient bit per cycle, then checks the block and
// commits or rejects it. The next item is taken in the cycle the result is shown.
// After reset, and after every write to one of the three registers, the controller sweeps
// the whole link memory, one entry a cycle; busy stays high meanwhile
// and register writes are still taken, a new write restarting the sweep.
// The result strobe, done, is high for exactly one cycle per item, and the receiver must
// take the item in that cycle.
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  fbpa_pkg::item_in_t           request,
	output logic                         busy,
	output logic                         done,
	output fbpa_pkg::item_out_t          result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
	input  logic [fbpa_pkg::PDATA_W-1:0] pwdata,
	output logic [fbpa_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import fbpa_pkg::*;

	localparam int CNTW = $clog2(MAX_BLOCKS + 1);

	logic [ADDR_W-1:0]  pool_base_q;
	logic [SIZE_W-1:0]  block_size_q;
	logic [COUNT_W-1:0] block_count_q;
	logic [SIZE_W-1:0]  eff_size;
	logic [CNTW-1:0]    eff_count;
	logic               cfg_write;
	logic               cfg_hit;
	logic               cfg_rebuild;
	cmd_t               cmd;
	stat_t              stat;

	// The register index sits in the word-address bits; the byte bits are ignored.
	assign cfg_write = psel & penable & pwrite;
	assign pready    = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			REG_POOL_BASE: begin
				cfg_hit = 1'b1;
				prdata  = pool_base_q;
			end
			REG_BLOCK_SIZE: begin
				cfg_hit = 1'b1;
				prdata  = PDATA_W'(block_size_q);
			end
			REG_BLOCK_COUNT: begin
				cfg_hit = 1'b1;
				prdata  = PDATA_W'(block_count_q);
			end
			default: begin
				cfg_hit = 1'b0;
				prdata  = '0;
			end
		endcase
	end

	// Any write to a defined register rebuilds the free list and clears the used count.
	assign cfg_rebuild = cfg_write & cfg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= 32'd65536;
			block_size_q  <= 17'd64;
			block_count_q <= 9'd256;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_POOL_BASE:   pool_base_q   <= pwdata;
				REG_BLOCK_SIZE:  block_size_q  <= pwdata[SIZE_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= pwdata[COUNT_W-1:0];
				default:         pool_base_q   <= pool_base_q;
			endcase
		end
	end

	// A block size of zero counts as one byte; a block count above the built
	// capacity counts as the capacity.
	assign eff_size  = (block_size_q == '0) ? SIZE_W'(1) : block_size_q;
	assign eff_count = (32'(block_count_q) > 32'(MAX_BLOCKS)) ? CNTW'(MAX_BLOCKS)
		: CNTW'(block_count_q);

	fbpa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cfg_rebuild (cfg_rebuild),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy)
	);

	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.request   (request),
		.pool_base (pool_base_q),
		.eff_size  (eff_size),
		.eff_count (eff_count),
		.result    (result),
		.done      (done)
	);

endmodule

FILE: rtl/fbpa_div.sv
// Serial restoring divider, one quotient bit per cycle.
module fbpa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
	input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
	output logic                        done,
	output logic [fbpa_pkg::ADDR_W-1:0] quot,
	output logic [fbpa_pkg::SIZE_W-1:0] rem
);
	import fbpa_pkg::*;

	localparam int CW = $clog2(ADDR_W);

	logic              running_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [ADDR_W-1:0] quo_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W:0]   shifted;
	logic [SIZE_W+1:0] trial;

	assign shifted = {rem_q, quo_q[ADDR_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ADDR_W - 1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (running_q) begin
			if (!trial[SIZE_W+1]) begin
				rem_q <= trial[SIZE_W-1:0];
				quo_q <= {quo_q[ADDR_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SIZE_W-1:0];
				quo_q <= {quo_q[ADDR_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/fbpa_dp.sv
// Datapath: free-list link memory, list head, used count, address arithmetic.
module fbpa_dp #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fbpa_pkg::cmd_t                       cmd,
	output fbpa_pkg::stat_t                      stat,
	input  fbpa_pkg::item_in_t                   request,
	input  logic [fbpa_pkg::ADDR_W-1:0]          pool_base,
	input  logic [fbpa_pkg::SIZE_W-1:0]          eff_size,
	input  logic [$clog2(MAX_BLOCKS+1)-1:0]      eff_count,
	output fbpa_pkg::item_out_t                  result,
	output logic                                 done
);
	import fbpa_pkg::*;

	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CNTW = $clog2(MAX_BLOCKS + 1);
	localparam int SPW  = SIZE_W + CNTW;
	localparam int PW   = IW + SIZE_W;

	logic [IW:0]       mem [MAX_BLOCKS];
	logic [IW:0]       rd_q;
	logic              we;
	logic [IW-1:0]     wa;
	logic [IW:0]       wd;

	logic [IW-1:0]     sweep_q;
	logic [IW-1:0]     head_q;
	logic              head_valid_q;
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] used_inc;
	logic [USED_W-1:0] used_dec;

	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] offset_q;
	logic [SPW-1:0]    span_q;
	logic [PW-1:0]     prod_q;
	item_out_t         res_q;
	logic              done_q;

	logic              div_done;
	logic [ADDR_W-1:0] quot;
	logic [SIZE_W-1:0] rem;

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.free_setup),
		.dividend (addr_q - pool_base),
		.divisor  (eff_size),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign used_inc = (used_q < USED_LIMIT) ? used_q + 1'b1 : used_q;
	assign used_dec = (used_q != '0) ? used_q - 1'b1 : used_q;

	// Sweep writes the rebuilt links; a free writes the old head into the freed block.
	assign we = cmd.sweep_step | cmd.free_commit;
	assign wa = cmd.sweep_step ? sweep_q : quot[IW-1:0];
	assign wd = cmd.sweep_step ? {sweep_q != '0, sweep_q - 1'b1} : {head_valid_q, head_q};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= '0;
			head_q       <= '0;
			head_valid_q <= 1'b0;
			used_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.alloc_commit | cmd.emit_empty | cmd.free_commit | cmd.free_reject;
			if (cmd.init_start) begin
				sweep_q      <= '0;
				head_q       <= IW'(eff_count - 1'b1);
				head_valid_q <= (eff_count != '0);
				used_q       <= '0;
			end
			if (cmd.sweep_step) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.alloc_commit) begin
				head_q       <= rd_q[IW-1:0];
				head_valid_q <= rd_q[IW];
				used_q       <= used_inc;
			end
			if (cmd.free_commit) begin
				head_q       <= quot[IW-1:0];
				head_valid_q <= 1'b1;
				used_q       <= used_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= request.address;
		end
		if (cmd.alloc_mul) begin
			prod_q <= head_q * eff_size;
		end
		if (cmd.free_setup) begin
			offset_q <= addr_q - pool_base;
			span_q   <= SPW'(eff_size) * SPW'(eff_count);
		end
		if (cmd.alloc_commit) begin
			res_q <= '{ST_ALLOCATED, pool_base + 32'(prod_q), used_inc};
		end else if (cmd.emit_empty) begin
			res_q <= '{ST_EMPTY, '0, used_q};
		end else if (cmd.free_commit) begin
			res_q <= '{ST_FREED, '0, used_dec};
		end else if (cmd.free_reject) begin
			res_q <= '{ST_REJECTED, '0, used_q};
		end
	end

	assign stat.sweep_last = (sweep_q == IW'(MAX_BLOCKS - 1));
	assign stat.head_valid = head_valid_q;
	assign stat.req_free   = (request.opcode == OP_FREE);
	assign stat.div_done   = div_done;
	assign stat.free_ok    = (addr_q != '0) && (eff_count != '0)
		&& (64'(offset_q) < 64'(span_q)) && (rem == '0);

	assign result = res_q;
	assign done   = done_q;

	a_done_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.alloc_commit || cmd.emit_empty || cmd.free_commit
			|| cmd.free_reject))
		else $error("result strobe without a finishing command");

	a_free_index_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.free_commit |-> (quot < 32'(eff_count)))
		else $error("freed block index outside the pool");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_commit |-> (head_valid_q && $past(cmd.alloc_mul)))
		else $error("allocation popped an empty list");

endmodule

FILE: rtl/fbpa_ctrl.sv
// Controller state machine: list rebuild sweep and per-item sequencing.
module fbpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            cfg_rebuild,
	input  fbpa_pkg::stat_t stat,
	output fbpa_pkg::cmd_t  cmd,
	output logic            busy
);
	import fbpa_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_SWEEP,
		S_IDLE,
		S_ALLOC_A,
		S_ALLOC_B,
		S_FREE_A,
		S_FREE_DIV,
		S_FREE_CHK
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else if (cfg_rebuild) begin
			state_q <= S_INIT;
		end else begin
			unique case (state_q)
				S_INIT: state_q <= S_SWEEP;
				S_SWEEP: begin
					if (stat.sweep_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) state_q <= stat.req_free ? S_FREE_A : S_ALLOC_A;
				end
				S_ALLOC_A: state_q <= stat.head_valid ? S_ALLOC_B : S_IDLE;
				S_ALLOC_B: state_q <= S_IDLE;
				S_FREE_A: state_q <= S_FREE_DIV;
				S_FREE_DIV: begin
					if (stat.div_done) state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: state_q <= S_IDLE;
				default: state_q <= S_INIT;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_INIT:     cmd.init_start = 1'b1;
			S_SWEEP:    cmd.sweep_step = 1'b1;
			S_IDLE:     cmd.capture = start;
			S_ALLOC_A: begin
				cmd.alloc_mul  = stat.head_valid;
				cmd.emit_empty = !stat.head_valid;
			end
			S_ALLOC_B:  cmd.alloc_commit = 1'b1;
			S_FREE_A:   cmd.free_setup = 1'b1;
			S_FREE_DIV: cmd = '0;
			S_FREE_CHK: begin
				cmd.free_commit = stat.free_ok;
				cmd.free_reject = !stat.free_ok;
			end
			default:    cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: verif/fixed_block_pool_allocator_test.sv
// Self-checking testbench of the fixed-size block pool allocator: directed and random items.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_test;
	import fbpa_pkg::*;

	// The block is built with its default capacity; the free list mirror below matches it.
	localparam int POOL_BLOCKS = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Request side, driven by the driver process below.
	logic start = 1'b0;
	item_in_t request = '0;
	logic busy;
	logic done;
	item_out_t result;

	// Register port, driven by the sequencing process through write_reg.
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	fixed_block_pool_allocator #(
		.MAX_BLOCKS(POOL_BLOCKS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the three registers as the block holds them.
	logic [ADDR_W-1:0] cfg_base;
	logic [SIZE_W-1:0] cfg_size;
	logic [COUNT_W-1:0] cfg_count;

	// Mirror of the LIFO free list: one link per block, each with its own valid bit.
	logic [COUNT_W-1:0] next_link [POOL_BLOCKS];
	bit link_ok [POOL_BLOCKS];
	logic [COUNT_W-1:0] list_head;
	bit head_ok;
	logic [USED_W-1:0] in_use;

	// Items waiting to be offered, and results owed by the block in order of acceptance.
	item_in_t pending_requests[$];
	item_out_t expected_results[$];

	int unsigned sender_idle_pct = 0;
	int unsigned items_sent = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;
	int unsigned settings_used = 1;

	// A block count above the built capacity is clipped to it.
	function automatic int unsigned live_blocks();
		return (cfg_count > POOL_BLOCKS) ? POOL_BLOCKS : int'(cfg_count);
	endfunction

	// A block size of zero behaves as a size of one.
	function automatic int unsigned stride();
		return (cfg_size == '0) ? 1 : int'(cfg_size);
	endfunction

	// Every register write puts all blocks back on the list with the highest on top.
	function automatic void rebuild_free_list();
		int unsigned n;
		n = live_blocks();
		for (int i = 0; i < POOL_BLOCKS; i++) begin
			link_ok[i] = (i > 0);
			next_link[i] = (i > 0) ? COUNT_W'(i - 1) : '0;
		end
		head_ok = (n > 0);
		list_head = (n > 0) ? COUNT_W'(n - 1) : '0;
		in_use = '0;
	endfunction

	// Works out the result of one accepted item and advances the free list mirror.
	function automatic item_out_t pool_predict(input item_in_t it);
		item_out_t r;
		int unsigned n;
		int unsigned sz;
		int unsigned idx;
		logic [ADDR_W-1:0] offset;
		logic [63:0] span;
		n = live_blocks();
		sz = stride();
		r.block_address = '0;
		if (it.opcode == OP_ALLOC) begin
			if (!head_ok) begin
				r.status = ST_EMPTY;
			end else begin
				idx = list_head;
				// The sum wraps at 32 bits, just as the ownership test does.
				r.block_address = cfg_base + ADDR_W'(idx * sz);
				head_ok = link_ok[idx];
				list_head = next_link[idx];
				if (in_use < USED_LIMIT)
					in_use = in_use + 1'b1;
				r.status = ST_ALLOCATED;
			end
		end else begin
			offset = it.address - cfg_base;
			span = 64'(sz) * 64'(n);
			if (it.address == '0 || n == 0 || 64'(offset) >= span || (offset % sz) != 0) begin
				r.status = ST_REJECTED;
			end else begin
				// No double-free detection: the block is pushed even if already free.
				idx = offset / sz;
				next_link[idx] = list_head;
				link_ok[idx] = head_ok;
				list_head = COUNT_W'(idx);
				head_ok = 1'b1;
				if (in_use > 0)
					in_use = in_use - 1'b1;
				r.status = ST_FREED;
			end
		end
		r.used_count = in_use;
		return r;
	endfunction

	// Driver: offers the oldest pending item and holds it until the block takes it.
	// When nothing is held, a random draw against sender_idle_pct may leave a gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(pool_predict(request));
				void'(pending_requests.pop_front());
				items_sent++;
			end
			if (start && busy) begin
				// The item is still on offer; it stays as it is.
			end else if (pending_requests.size() != 0
					&& $urandom_range(99) >= sender_idle_pct) begin
				start <= 1'b1;
				request <= pending_requests[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	// Monitor: every strobed result is checked field by field against the oldest expectation.
	always @(posedge clk) begin
		item_out_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", '0, result.block_address);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (result.status !== want.status)
					report_mismatch("status", 32'(want.status), 32'(result.status));
				if (result.block_address !== want.block_address)
					report_mismatch("block_address", want.block_address, result.block_address);
				if (result.used_count !== want.used_count)
					report_mismatch("used_count", 32'(want.used_count), 32'(result.used_count));
			end
		end
	end

	// One register write: a setup cycle, then an access cycle that ends on the write edge.
	// The mirror follows at that same edge; no item is in flight when this runs.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_POOL_BASE: cfg_base = value;
			REG_BLOCK_SIZE: cfg_size = value[SIZE_W-1:0];
			REG_BLOCK_COUNT: cfg_count = value[COUNT_W-1:0];
			default: ;
		endcase
		rebuild_free_list();
	endtask

	task automatic configure(input logic [31:0] base, input logic [31:0] size,
			input logic [31:0] count);
		write_reg(REG_POOL_BASE, base);
		write_reg(REG_BLOCK_SIZE, size);
		write_reg(REG_BLOCK_COUNT, count);
		settings_used++;
	endtask

	// Waits until every item has been taken and every expected result has come back.
	// The block's sweep after a register write simply shows up as busy to the driver.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || start || expected_results.size() != 0);
	endtask

	task automatic push_item(input op_t op, input logic [31:0] addr);
		item_in_t it;
		it.opcode = op;
		it.address = addr;
		pending_requests.push_back(it);
	endtask

	// Random item shaped for the current pool: half allocations, most frees aimed at real
	// blocks so they get through the ownership test, and the rest off by a little or a lot.
	function automatic item_in_t make_item();
		item_in_t it;
		int unsigned pick;
		int unsigned n;
		int unsigned sz;
		int unsigned k;
		n = live_blocks();
		sz = stride();
		pick = $urandom_range(99);
		it.opcode = OP_ALLOC;
		it.address = $urandom();
		if (pick >= 50) begin
			it.opcode = OP_FREE;
			k = (n > 0) ? $urandom_range(n - 1) : 0;
			it.address = cfg_base + ADDR_W'(k * sz);
			if (pick >= 85) begin
				case ($urandom_range(4))
					0: it.address = $urandom();
					1: it.address = it.address + ADDR_W'($urandom_range((sz > 1) ? sz - 1 : 1, 1));
					2: it.address = cfg_base + ADDR_W'(n * sz);
					3: it.address = cfg_base - ADDR_W'(sz);
					default: it.address = '0;
				endcase
			end
		end
		return it;
	endfunction

	// A random stretch; halfway through the sender holds back until all results are in.
	task automatic run_items(input int unsigned count, input int unsigned idle_pct);
		sender_idle_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain();
			pending_requests.push_back(make_item());
		end
		drain();
	endtask

	// Sequencing: reset, then a series of register settings, each with its own items.
	initial begin
		int unsigned sz;
		int unsigned n;
		cfg_base = 32'h0001_0000;
		cfg_size = SIZE_W'(64);
		cfg_count = COUNT_W'(256);
		rebuild_free_list();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting. A free at a used count of zero, both ends of the list, and a free
		// address that is zero, misaligned, one block past the end, below the base and all ones.
		push_item(OP_FREE, 32'h0001_0000);
		push_item(OP_ALLOC, 32'h0);
		push_item(OP_ALLOC, 32'hFFFF_FFFF);
		push_item(OP_FREE, 32'h0);
		push_item(OP_FREE, 32'h0001_0001);
		push_item(OP_FREE, 32'h0001_0000 + 256 * 64);
		push_item(OP_FREE, 32'h0001_0000 - 64);
		push_item(OP_FREE, 32'hFFFF_FFFF);
		push_item(OP_FREE, 32'h0001_0000 + 255 * 64);
		drain();
		run_items(90, 57);

		// A pool that wraps past the top of the address space: one block sits at address
		// zero, is handed out, but can never be given back.
		configure(32'hFFFF_FFE0, 32'd16, 32'd8);
		for (int i = 0; i < 9; i++)
			push_item(OP_ALLOC, 32'h0);
		push_item(OP_FREE, 32'h0);
		push_item(OP_FREE, 32'hFFFF_FFF0);
		drain();
		run_items(90, 14);

		// Base zero, a zero block size and a block count above capacity.
		configure(32'h0, 32'd0, 32'd511);
		push_item(OP_FREE, 32'h0);
		push_item(OP_FREE, 32'd255);
		push_item(OP_FREE, 32'd256);
		push_item(OP_ALLOC, 32'h0);
		drain();
		run_items(90, 0);

		// A block size of 65536, with the second block wrapping to address zero.
		configure(32'hFFFF_0000, 32'd65536, 32'd3);
		for (int i = 0; i < 4; i++)
			push_item(OP_ALLOC, 32'h0);
		drain();
		run_items(90, 57);

		// An empty pool: allocations report empty and every free is turned away.
		configure(32'hFFFF_FFFF, 32'd1, 32'd0);
		run_items(60, 14);

		// All seventeen size bits set, at a random base and count.
		configure($urandom(), 32'h0001_FFFF, $urandom_range(256, 1));
		run_items(50, 57);

		configure($urandom(), $urandom_range(65536, 1), $urandom_range(256, 1));
		run_items(50, 0);

		// Saturation of the used count. Freeing the block on top of a fresh list links it
		// to itself, so from then on every allocation succeeds and the count climbs to its
		// ceiling and stays there. A rejected free every hundred items is mixed in as noise.
		configure($urandom(), $urandom_range(300, 1), $urandom_range(256, 2));
		sz = stride();
		n = live_blocks();
		sender_idle_pct = 57;
		push_item(OP_FREE, cfg_base + ADDR_W'((n - 1) * sz));
		for (int i = 0; i < 520; i++) begin
			if (i % 100 == 99)
				push_item(OP_FREE, 32'h0);
			else
				push_item(OP_ALLOC, $urandom());
		end
		drain();

		repeat (10) @(posedge clk);
		$display("Sent %0d items over %0d register settings; %0d results checked.",
			items_sent, settings_used, results_checked);
		$display("Covered allocations, empty pools, accepted and rejected frees, address wrap",
			" and both limits of the used count.");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: many times the slowest correct run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d items pending and %0d results owed.",
			pending_requests.size(), expected_results.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
